[hdl/lpd_pkg.sv]
package lpd_pkg;

  // kind codes of an input word
  localparam logic [1:0] KIND_FRONT  = 2'd0;
  localparam logic [1:0] KIND_BACK   = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // depth of the command queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               is_last;
    logic               list_empty;
    logic               dropped;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_FRONT  = 2'd0,
    OP_BACK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [5:0]         position;
  } cmd_t;

endpackage

[hdl/list_push_delete_at_index_core.sv]
// ordered list of up to CAPACITY signed values in a circular store. each word
// pushes a value at the front, pushes one at the back, or deletes the element
// at a position (later elements close the gap); anything else leaves the list
// as it is. after every word the whole list is sent front to back, one result
// per cycle on out_strobe/out_word, with is_last on the final one; an empty
// list gives a single result with list_empty set and element zero, and a push
// onto a full list is refused with dropped set on every result of its listing.
// a word is taken when start is high and busy is low; two words can wait in
// the command queue, and busy is high only while that queue is full. results
// cannot be held off: each is on the ports for exactly one cycle.
// per word the back end picks it up from the queue while idle, then lists the
// entries in order (one result for an empty list), since the list store has one
// read port and gives one element a cycle; the last result leaves while the back
// end picks up the next word. a delete from the middle first moves the later
// entries one place nearer the front through the same port; the slowest word is
// a delete at position one on a full list.
// the store needs no clearing after reset: only live entries are ever read
module list_push_delete_at_index_core #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lpd_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output lpd_pkg::out_word_t out_word
);
  import lpd_pkg::*;

  // command handed from the front queue to the back end
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // front: takes words, turns kind into an operation, queues them
  lpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // back: owns the store, front pointer and count; updates and lists
  lpd_back #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

endmodule

[hdl/lpd_ram.sv]
module lpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/lpd_front.sv]
module lpd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lpd_pkg::in_word_t in_word,
  output logic             cmd_valid,
  output lpd_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);
  import lpd_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  cmd_t            q_r [QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  cmd_t            cmd_in;
  logic            push;
  logic            pop;

  // classify the incoming word
  always_comb begin
    cmd_in.value    = in_word.value;
    cmd_in.position = in_word.position;
    case (in_word.kind)
      KIND_FRONT:  cmd_in.op = OP_FRONT;
      KIND_BACK:   cmd_in.op = OP_BACK;
      KIND_DELETE: cmd_in.op = OP_DELETE;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  assign busy      = (cnt_r == NW'(QDEPTH));
  assign push      = start & ~busy;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop & cmd_valid;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = NW'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = NW'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hdl/lpd_back.sv]
module lpd_back #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  lpd_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_strobe,
  output lpd_pkg::out_word_t out_word
);
  import lpd_pkg::*;

  localparam int unsigned SW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;
  localparam int unsigned VW   = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_LIST  = 3'b100
  } back_state_t;

  back_state_t           state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [SW-1:0]         fp_r, fp_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         wr_idx_r, wr_idx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  drop_r, drop_nxt;
  logic                  emit_r, emit_nxt;
  logic                  last_r, last_nxt;
  logic                  empty_r, empty_nxt;
  logic                  drop_out_r, drop_out_nxt;

  logic                  we, re;
  logic [SW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  logic [VW-1:0]         push_ext;
  logic [VW-1:0]         rd_ext;
  logic [CW-1:0]         pos_c;
  logic                  pos_ok;
  logic                  full;
  logic [SW-1:0]         fp_inc, fp_dec;

  // circular slot of logical index off
  function automatic logic [SW-1:0] slot_f(input logic [SW-1:0] base,
                                           input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return SW'(s);
  endfunction

  lpd_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign push_ext = VW'(cmd.value);
  assign pos_ok   = CMPW'(cmd.position) < CMPW'(count_r);
  assign pos_c    = CW'(cmd.position);
  assign full     = (count_r == CW'(CAPACITY));
  assign fp_inc   = (fp_r == SW'(CAPACITY - 1)) ? '0 : SW'(fp_r + 1'b1);
  assign fp_dec   = (fp_r == '0) ? SW'(CAPACITY - 1) : SW'(fp_r - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    fp_nxt       = fp_r;
    idx_nxt      = idx_r;
    wr_idx_nxt   = wr_idx_r;
    pend_nxt     = 1'b0;
    drop_nxt     = drop_r;
    emit_nxt     = 1'b0;
    last_nxt     = last_r;
    empty_nxt    = empty_r;
    drop_out_nxt = drop_out_r;
    cmd_pop      = 1'b0;
    we           = 1'b0;
    waddr        = slot_f(fp_r, count_r);
    wdata        = push_ext[VALUE_BITS-1:0];
    re           = 1'b0;
    raddr        = slot_f(fp_r, idx_r);

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          drop_nxt  = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_LIST;
          case (cmd.op)
            OP_FRONT: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                we        = 1'b1;
                waddr     = fp_dec;
                fp_nxt    = fp_dec;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            OP_BACK: begin
              if (full) begin
                drop_nxt = 1'b1;
              end else begin
                we        = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            OP_DELETE: begin
              if (pos_ok) begin
                if (pos_c == '0) begin
                  // front element leaves: just advance the front
                  count_nxt = CW'(count_r - 1'b1);
                  fp_nxt    = (count_r == CW'(1)) ? '0 : fp_inc;
                end else if (pos_c == CW'(count_r - 1'b1)) begin
                  count_nxt = CW'(count_r - 1'b1);
                end else begin
                  idx_nxt    = CW'(pos_c + 1'b1);
                  wr_idx_nxt = pos_c;
                  state_nxt  = ST_SHIFT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // read entry idx, write it one place nearer the front once its registered read data is back
        if (idx_r < count_r) begin
          re       = 1'b1;
          idx_nxt  = CW'(idx_r + 1'b1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          we         = 1'b1;
          waddr      = slot_f(fp_r, wr_idx_r);
          wdata      = rdata;
          wr_idx_nxt = CW'(wr_idx_r + 1'b1);
        end
        if (!pend_r && !(idx_r < count_r)) begin
          count_nxt = CW'(count_r - 1'b1);
          idx_nxt   = '0;
          state_nxt = ST_LIST;
        end
      end

      ST_LIST: begin
        emit_nxt     = 1'b1;
        drop_out_nxt = drop_r;
        if (count_r == '0) begin
          last_nxt  = 1'b1;
          empty_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          re        = 1'b1;
          empty_nxt = 1'b0;
          last_nxt  = (idx_r == CW'(count_r - 1'b1));
          idx_nxt   = CW'(idx_r + 1'b1);
          if (idx_r == CW'(count_r - 1'b1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      fp_r       <= '0;
      idx_r      <= '0;
      wr_idx_r   <= '0;
      pend_r     <= 1'b0;
      drop_r     <= 1'b0;
      emit_r     <= 1'b0;
      last_r     <= 1'b0;
      empty_r    <= 1'b0;
      drop_out_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      fp_r       <= fp_nxt;
      idx_r      <= idx_nxt;
      wr_idx_r   <= wr_idx_nxt;
      pend_r     <= pend_nxt;
      drop_r     <= drop_nxt;
      emit_r     <= emit_nxt;
      last_r     <= last_nxt;
      empty_r    <= empty_nxt;
      drop_out_r <= drop_out_nxt;
    end
  end

  // stored values shorter than 32 bits come out zero-extended
  assign rd_ext     = VW'(rdata);
  assign out_strobe = emit_r;

  always_comb begin
    out_word.element    = empty_r ? '0 : $signed(rd_ext[31:0]);
    out_word.is_last    = last_r;
    out_word.list_empty = empty_r;
    out_word.dropped    = drop_out_r;
  end

endmodule

[verif/list_push_delete_at_index_checker.sv]
`timescale 1ns / 1ps

module list_push_delete_at_index_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  lpd_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  lpd_pkg::out_word_t out_word,
  output int                 errors,
  output int                 pending
);
  import lpd_pkg::*;

  logic signed [31:0] list_contents[$];
  out_word_t          listing_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // apply one word to the list copy and queue the listing it produces
  task automatic predict_listing(input in_word_t w);
    op_t       op;
    bit        refused;
    out_word_t r;
    int        i;
    begin
      op      = op_t'(w.kind);
      refused = 1'b0;
      case (op)
        OP_FRONT, OP_BACK: begin
          if (list_contents.size() >= CAPACITY) refused = 1'b1;
          else if (op == OP_FRONT) list_contents.push_front(w.value);
          else list_contents.push_back(w.value);
        end
        OP_DELETE: begin
          if (w.position < list_contents.size()) list_contents.delete(w.position);
        end
        default: ;
      endcase
      if (list_contents.size() == 0) begin
        r.element    = '0;
        r.is_last    = 1'b1;
        r.list_empty = 1'b1;
        r.dropped    = refused;
        listing_q.push_back(r);
      end else begin
        for (i = 0; i < list_contents.size(); i++) begin
          r.element    = list_contents[i];
          r.is_last    = (i == list_contents.size() - 1);
          r.list_empty = 1'b0;
          r.dropped    = refused;
          listing_q.push_back(r);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    begin
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %0d got %0d", $time, name, $signed(exp_v),
                 $signed(act_v));
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      // results first: a word taken at this edge cannot have a result yet
      if (out_strobe !== 1'b0) begin
        if (listing_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got element %0d strobe %b",
                   $time, out_word.element, out_strobe);
          errors++;
        end else begin
          exp_w = listing_q.pop_front();
          check_field("strobe", 32'd1, {31'd0, out_strobe});
          check_field("element", exp_w.element, out_word.element);
          check_field("is_last", {31'd0, exp_w.is_last}, {31'd0, out_word.is_last});
          check_field("list_empty", {31'd0, exp_w.list_empty},
                      {31'd0, out_word.list_empty});
          check_field("dropped", {31'd0, exp_w.dropped}, {31'd0, out_word.dropped});
        end
      end
      if (start && !busy) predict_listing(in_word);
    end
    pending = listing_q.size();
  end

endmodule

[verif/list_push_delete_at_index_core_tb.sv]
`timescale 1ns / 1ps

module list_push_delete_at_index_core_tb;
  import lpd_pkg::*;

  localparam int unsigned CAPACITY   = 32;
  localparam int          RAND_WORDS = 300;
  // longest quiet spell allowed, set well beyond the slowest case, a full-list
  // delete plus its listing, with the sender's idle gaps on top
  localparam int          STALL_LIMIT = 1000;
  localparam int          TAIL_CYCLES = 2 * CAPACITY + 16;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;
  int        errors;
  int        pending;
  int        stall_cycles;

  list_push_delete_at_index_core #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // watches both channels, keeps its own list and compares every result
  list_push_delete_at_index_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: quiet cycles with neither a word taken nor a result given
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // mostly random 32-bit values, now and then one of the extremes
  function automatic logic signed [31:0] random_value();
    int pick;
    begin
      pick = $urandom_range(0, 99);
      if (pick < 3) return 32'sh7fffffff;
      if (pick < 6) return 32'sh80000000;
      if (pick < 8) return '0;
      if (pick < 10) return -32'sd1;
      return $urandom;
    end
  endfunction

  // push_pct sets how hard the list is driven towards full
  function automatic in_word_t random_word(input int push_pct);
    in_word_t w;
    int       roll;
    begin
      roll    = $urandom_range(0, 99);
      w.value = random_value();
      if (roll < 3) w.kind = OP_NONE;
      else if (roll < 3 + push_pct) w.kind = $urandom_range(0, 1) ? KIND_FRONT : KIND_BACK;
      else w.kind = KIND_DELETE;
      // deletes mostly land near the live range, the rest anywhere in 0..63
      if (w.kind == KIND_DELETE && $urandom_range(0, 9) < 7)
        w.position = 6'($urandom_range(0, CAPACITY + 1));
      else w.position = 6'($urandom_range(0, 63));
      return w;
    end
  endfunction

  // present one word from the falling edge and hold it until it is taken
  task automatic send_word(input in_word_t w);
    begin
      @(negedge clk);
      start   = 1'b1;
      in_word = w;
      do @(posedge clk); while (busy);
    end
  endtask

  task automatic idle_cycles(input int n);
    begin
      repeat (n) begin
        @(negedge clk);
        start   = 1'b0;
        in_word = random_word(50);
      end
    end
  endtask

  // hold off until the whole backlog of results has come out
  task automatic drain_listings();
    begin
      @(negedge clk);
      start = 1'b0;
      while (pending != 0) @(negedge clk);
    end
  endtask

  task automatic send_directed(input logic [1:0] kind, input logic signed [31:0] value,
                               input logic [5:0] position);
    in_word_t w;
    begin
      w.kind     = kind;
      w.value    = value;
      w.position = position;
      if ($urandom_range(0, 99) < 7) idle_cycles($urandom_range(1, 5));
      send_word(w);
    end
  endtask

  initial begin
    int idx;
    int push_pct;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    stall_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    // delete and unused kind on an empty list: nothing changes
    send_directed(KIND_DELETE, 32'sd0, 6'd0);
    send_directed(OP_NONE, 32'sh7fffffff, 6'h3f);
    // one element, then delete the last remaining one
    send_directed(KIND_BACK, 32'sh7fffffff, 6'h3f);
    send_directed(KIND_DELETE, -32'sd1, 6'd0);
    // push after emptying must not see a stale back end
    send_directed(KIND_BACK, 32'sd1, 6'd0);
    send_directed(KIND_FRONT, 32'sh80000000, 6'h2a);
    send_directed(KIND_FRONT, -32'sd1, 6'h15);
    send_directed(KIND_BACK, 32'sd0, 6'h3f);
    // out of range: far beyond and exactly at the count
    send_directed(KIND_DELETE, 32'sh55555555, 6'h3f);
    send_directed(KIND_DELETE, 32'shaaaaaaaa, 6'd4);
    // middle, back end, then front
    send_directed(KIND_DELETE, 32'sd0, 6'd1);
    send_directed(KIND_DELETE, 32'sd0, 6'd2);
    send_directed(OP_NONE, 32'sh80000000, 6'd0);
    send_directed(KIND_DELETE, 32'sd0, 6'd0);
    send_directed(KIND_DELETE, 32'sd0, 6'd0);
    send_directed(KIND_FRONT, 32'sh5555aaaa, 6'h2a);
    send_directed(KIND_BACK, 32'shaaaa5555, 6'h15);
    send_directed(KIND_DELETE, 32'sd0, 6'd1);
    drain_listings();

    // random part, in phases that fill, drain, overfill and churn the list
    for (idx = 0; idx < RAND_WORDS; idx++) begin
      if (idx < 60) push_pct = 65;
      else if (idx < 120) push_pct = 35;
      else if (idx < 180) push_pct = 92;
      else if (idx < 240) push_pct = 30;
      else push_pct = 55;
      // the overfill phase adds no idle gaps, apart from the drain at word 150
      if ((idx < 120 || idx >= 180) && $urandom_range(0, 99) < 7)
        idle_cycles($urandom_range(1, 6));
      if (idx == 150 || idx == 250) drain_listings();
      send_word(random_word(push_pct));
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    // let any stray results show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
